@@ design/eia_pkg.sv @@
// Shared types and constants for the entity ID allocator.
`timescale 1ns / 1ps
package eia_pkg;

    // Sizing
    localparam int MAX_ENTITIES   = 1024;
    localparam int MAX_COMPONENTS = 64;
    localparam int ID_W           = $clog2(MAX_ENTITIES);
    localparam int CNT_W          = $clog2(MAX_ENTITIES + 1);
    localparam int SIG_W          = MAX_COMPONENTS;

    // Fixed field widths of the request and response words
    localparam int ACT_W  = 3;
    localparam int ENT_W  = 10;
    localparam int COMP_W = 6;
    localparam int STAT_W = 2;

    typedef enum logic [ACT_W-1:0] {
        ACT_CREATE    = 3'd0,
        ACT_DESTROY   = 3'd1,
        ACT_ALIVE     = 3'd2,
        ACT_SET       = 3'd3,
        ACT_CLEAR     = 3'd4,
        ACT_TEST      = 3'd5,
        ACT_CLEAR_ALL = 3'd6
    } t_action;

    // Spare action code: changes nothing, answers all zero
    localparam logic [ACT_W-1:0] ACT_UNUSED = 3'd7;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE   = 2'd0,
        ST_FULL   = 2'd1,
        ST_BAD_ID = 2'd2
    } t_status;

    // Controller to datapath
    typedef struct packed {
        logic capture;   // request word taken, launch memory reads
        logic commit;    // apply updates and load the response register
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic out_valid; // response register holds a word
    } t_stat;

endpackage

@@ design/eia_if.sv @@
// Request and response channel interfaces of the entity ID allocator.
`timescale 1ns / 1ps
interface eia_req_if import eia_pkg::*;;
    logic              valid;
    logic              ready;
    logic [ACT_W-1:0]  action;
    logic [ENT_W-1:0]  entity;
    logic [COMP_W-1:0] component;

    modport source (output valid, output action, output entity, output component,
                    input ready);
    modport sink   (input valid, input action, input entity, input component,
                    output ready);
endinterface

interface eia_rsp_if import eia_pkg::*;;
    logic              valid;
    logic              ready;
    logic [ENT_W-1:0]  new_entity;
    logic              answer_flag;
    logic [STAT_W-1:0] status;

    modport source (output valid, output new_entity, output answer_flag, output status,
                    input ready);
    modport sink   (input valid, input new_entity, input answer_flag, input status,
                    output ready);
endinterface

@@ design/entity_id_allocator_with_signatures.sv @@
// Top level of the entity ID allocator with per-entity component signatures.
//
//  Channel  | Dir | Handshake      | Word
//  ---------+-----+----------------+--------------------------------------
//  i_req    | in  | valid / ready  | action, entity, component
//  o_rsp    | out | valid / ready  | new_entity, answer_flag, status
//
// Each request passes a read step, which reads the free stack, alive map and
// signature row (registered RAM reads), and a commit step, which applies the
// update and loads the response register. A new request is taken only once
// the last has committed. A waiting response stalls that commit; then the next
// request is taken even while the response register is full. Reset clears the
// counters and the handshake state; the memories need no clearing.
`timescale 1ns / 1ps
module entity_id_allocator_with_signatures import eia_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    eia_req_if.sink      i_req,
    eia_rsp_if.source    o_rsp
);

    t_cmd  cmd;
    t_stat stat;
    logic  in_ready;

    eia_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_out_ready (o_rsp.ready),
        .i_stat      (stat),
        .o_in_ready  (in_ready),
        .o_cmd       (cmd)
    );

    eia_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_action      (i_req.action),
        .i_entity      (i_req.entity),
        .i_component   (i_req.component),
        .i_out_ready   (o_rsp.ready),
        .o_stat        (stat),
        .o_out_valid   (o_rsp.valid),
        .o_new_entity  (o_rsp.new_entity),
        .o_answer_flag (o_rsp.answer_flag),
        .o_status      (o_rsp.status)
    );

    assign i_req.ready = in_ready;

endmodule

@@ design/eia_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
module eia_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write on write enable; read on read enable, old word on an address collision
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/eia_ctrl.sv @@
// Controller state machine: takes one request word, then commits it.
`timescale 1ns / 1ps
module eia_ctrl import eia_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output logic  o_in_ready,
    output t_cmd  o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   can_commit;

    // Commit once the response register is free or being emptied
    assign can_commit    = !i_stat.out_valid || i_out_ready;
    assign o_in_ready    = (r_state == S_IDLE);
    assign o_cmd.capture = o_in_ready && i_in_valid;
    assign o_cmd.commit  = (r_state == S_EXEC) && can_commit;

    // Advance the state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (can_commit) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ design/eia_dp.sv @@
// Datapath: counters, free stack, alive map, signature rows and response register.
`timescale 1ns / 1ps
module eia_dp import eia_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  logic [ACT_W-1:0]  i_action,
    input  logic [ENT_W-1:0]  i_entity,
    input  logic [COMP_W-1:0] i_component,
    input  logic              i_out_ready,
    output t_stat             o_stat,
    output logic              o_out_valid,
    output logic [ENT_W-1:0]  o_new_entity,
    output logic              o_answer_flag,
    output logic [STAT_W-1:0] o_status
);

    localparam logic [CNT_W-1:0] CntMax = CNT_W'(MAX_ENTITIES);

    // Captured request word
    logic [ACT_W-1:0]  r_action;
    logic [ENT_W-1:0]  r_entity;
    logic [COMP_W-1:0] r_comp;

    // Allocation counters
    logic [CNT_W-1:0] r_free_count, n_free_count;
    logic [CNT_W-1:0] r_next_unused, n_next_unused;

    // Response register
    logic              r_out_valid;
    logic [ENT_W-1:0]  r_new_entity, n_new_entity;
    logic              r_answer, n_answer;
    t_status           r_status, n_status;

    // Memory ports
    logic [ID_W-1:0]  stack_rdata, stack_waddr;
    logic             stack_we;
    logic             alive_rdata, alive_we, alive_wdata;
    logic [ID_W-1:0]  row_waddr, ent_id;
    logic [SIG_W-1:0] sig_rdata, sig_wdata, mask;
    logic             sig_we, alive_we_raw, sig_we_raw, stack_we_raw;
    logic             id_ok, comp_ok;

    // Launch reads when a request word is taken
    eia_ram #(.WIDTH(ID_W), .DEPTH(MAX_ENTITIES)) u_stack (
        .i_clk   (i_clk),
        .i_we    (stack_we),
        .i_waddr (stack_waddr),
        .i_wdata (ent_id),
        .i_re    (i_cmd.capture),
        .i_raddr (ID_W'(r_free_count - CNT_W'(1))),
        .o_rdata (stack_rdata)
    );

    eia_ram #(.WIDTH(1), .DEPTH(MAX_ENTITIES)) u_alive (
        .i_clk   (i_clk),
        .i_we    (alive_we),
        .i_waddr (row_waddr),
        .i_wdata (alive_wdata),
        .i_re    (i_cmd.capture),
        .i_raddr (ID_W'(i_entity)),
        .o_rdata (alive_rdata)
    );

    eia_ram #(.WIDTH(SIG_W), .DEPTH(MAX_ENTITIES)) u_sig (
        .i_clk   (i_clk),
        .i_we    (sig_we),
        .i_waddr (row_waddr),
        .i_wdata (sig_wdata),
        .i_re    (i_cmd.capture),
        .i_raddr (ID_W'(i_entity)),
        .o_rdata (sig_rdata)
    );

    // Decode the held word
    assign ent_id  = ID_W'(r_entity);
    assign id_ok   = CNT_W'(r_entity) < r_next_unused;
    assign comp_ok = 32'(r_comp) < 32'(MAX_COMPONENTS);
    assign mask    = comp_ok ? (SIG_W'(1) << r_comp) : '0;
    assign stack_waddr = ID_W'(r_free_count);

    // Work out updates and the response word
    always_comb begin
        n_free_count  = r_free_count;
        n_next_unused = r_next_unused;
        n_new_entity  = '0;
        n_answer      = 1'b0;
        n_status      = ST_DONE;
        row_waddr     = ent_id;
        alive_wdata   = 1'b0;
        sig_wdata     = '0;
        alive_we_raw  = 1'b0;
        sig_we_raw    = 1'b0;
        stack_we_raw  = 1'b0;
        unique case (t_action'(r_action))
            ACT_CREATE: begin
                if (r_free_count != '0) begin
                    n_free_count = r_free_count - CNT_W'(1);
                    row_waddr    = stack_rdata;
                    alive_we_raw = 1'b1;
                    sig_we_raw   = 1'b1;
                    alive_wdata  = 1'b1;
                    n_new_entity = ENT_W'(stack_rdata);
                end else if (r_next_unused < CntMax) begin
                    n_next_unused = r_next_unused + CNT_W'(1);
                    row_waddr     = ID_W'(r_next_unused);
                    alive_we_raw  = 1'b1;
                    sig_we_raw    = 1'b1;
                    alive_wdata   = 1'b1;
                    n_new_entity  = ENT_W'(r_next_unused);
                end else begin
                    n_status = ST_FULL;
                end
            end
            ACT_DESTROY: begin
                if (!id_ok || !alive_rdata) begin
                    n_status = ST_BAD_ID;
                end else begin
                    alive_we_raw = 1'b1;
                    sig_we_raw   = 1'b1;
                    if (r_free_count < CntMax) begin
                        stack_we_raw = 1'b1;
                        n_free_count = r_free_count + CNT_W'(1);
                    end
                end
            end
            ACT_ALIVE: begin
                n_answer = id_ok && alive_rdata;
            end
            ACT_SET: begin
                if (!id_ok) begin
                    n_status = ST_BAD_ID;
                end else begin
                    sig_we_raw = 1'b1;
                    sig_wdata  = sig_rdata | mask;
                end
            end
            ACT_CLEAR: begin
                if (!id_ok) begin
                    n_status = ST_BAD_ID;
                end else begin
                    sig_we_raw = 1'b1;
                    sig_wdata  = sig_rdata & ~mask;
                end
            end
            ACT_TEST: begin
                if (!id_ok) begin
                    n_status = ST_BAD_ID;
                end else begin
                    n_answer = (sig_rdata & mask) != '0;
                end
            end
            ACT_CLEAR_ALL: begin
                n_free_count  = '0;
                n_next_unused = '0;
            end
            default: ;
        endcase
    end

    // Write memories only on commit
    assign alive_we = alive_we_raw && i_cmd.commit;
    assign sig_we   = sig_we_raw && i_cmd.commit;
    assign stack_we = stack_we_raw && i_cmd.commit;

    // Hold the request word
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_action <= i_action;
            r_entity <= i_entity;
            r_comp   <= i_component;
        end
    end

    // Advance counters and the response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_count  <= '0;
            r_next_unused <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_free_count  <= n_free_count;
                r_next_unused <= n_next_unused;
                r_out_valid   <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid   <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_new_entity <= n_new_entity;
            r_answer     <= n_answer;
            r_status     <= n_status;
        end
    end

    assign o_stat.out_valid = r_out_valid;
    assign o_out_valid      = r_out_valid;
    assign o_new_entity     = r_new_entity;
    assign o_answer_flag    = r_answer;
    assign o_status         = r_status;

endmodule
